// ===== design/ffa_pkg.sv =====
package ffa_pkg;

  // Default depth of the free range list
  localparam int DEFAULT_MAX_FREE_RANGES = 64;

  // Request codes
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_ALIGN = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOSPACE   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ZEROALIGN = 2'd3;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] SIZE_MAX = 32'hFFFF_FF00;
  localparam logic [32:0] RND_ADD  = 33'd255;
  localparam logic [32:0] RND_MASK = ~33'd255;

  // Remainder unit takes one dividend bit per cycle
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {RD_IDX, RD_IDX_P1, RD_IDX_M1} rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_TRIM, WR_SHIFT, WR_MERGE_PREV, WR_MERGE_NEXT, WR_INSERT
  } wr_op_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_INC, IDX_DEC, IDX_SET_COUNT} idx_op_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_ONE, CNT_INC, CNT_DEC} cnt_op_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_ALLOC_OK, RES_NOSPACE, RES_ZALIGN, RES_FREE_OK, RES_FREE_NOSPACE,
    RES_FULL
  } res_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    mod_start;
    logic    prev_ld;
    logic    pos_ld;
    wr_op_t  wr;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    res_op_t res;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] func;
    logic       size_big;
    logic       end_big;
    logic       align_zero;
    logic       idx_lt_cnt;
    logic       more_rm;
    logic       idx_gt_pos;
    logic       fit;
    logic       exact;
    logic       below;
    logic       mnext;
    logic       mprev;
    logic       full;
    logic       mod_busy;
  } sts_t;

endpackage

// ===== design/first_fit_free_list_allocator.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   func, request_size, alignment, free_offset
// out       output     out_valid / out_ready result_offset, status
// cfg       input      cfg_we                cfg_wdata (pool size)
//
// One request at a time. An allocate reads, waits on and checks each range it scans
// (an aligned allocate also runs the bit-serial remainder unit before the check),
// then reads and writes each later entry to close the gap when a range is removed;
// a free reads and compares each range it scans, then reads and writes each entry
// moved to close or open a gap.
// After reset the first list entry is written before the input is ready.
// A result waiting on out_ready holds off the next input transfer.
module first_fit_free_list_allocator #(
  parameter int MAX_FREE_RANGES = ffa_pkg::DEFAULT_MAX_FREE_RANGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] request_size,
  input  logic [31:0] alignment,
  input  logic [31:0] free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_offset,
  output logic [1:0]  status
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffa_dp #(
    .MAX_FREE_RANGES (MAX_FREE_RANGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .func          (func),
    .request_size  (request_size),
    .alignment     (alignment),
    .free_offset   (free_offset),
    .cmd           (cmd),
    .sts           (sts),
    .result_offset (result_offset),
    .status        (status)
  );

endmodule

// ===== design/ffa_mod.sv =====
module ffa_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] rem
);

  localparam int SW = $clog2(ffa_pkg::DIV_STEPS + 1);

  logic [31:0] dvd;
  logic [SW-1:0] steps;
  logic [32:0] trial;

  // Restoring remainder, one dividend bit per cycle
  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= SW'(ffa_pkg::DIV_STEPS);
      rem   <= '0;
      dvd   <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 32'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[31:0];
      end
      dvd   <= {dvd[30:0], 1'b0};
      steps <= steps - SW'(1);
      if (steps == SW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ffa_dp.sv =====
module ffa_dp #(
  parameter int MAX_FREE_RANGES = ffa_pkg::DEFAULT_MAX_FREE_RANGES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  input  logic [1:0]     func,
  input  logic [31:0]    request_size,
  input  logic [31:0]    alignment,
  input  logic [31:0]    free_offset,
  input  ffa_pkg::cmd_t  cmd,
  output ffa_pkg::sts_t  sts,
  output logic [31:0]    result_offset,
  output logic [1:0]     status
);

  localparam int AW = $clog2(MAX_FREE_RANGES);
  localparam int CW = $clog2(MAX_FREE_RANGES + 1);

  logic [31:0] start_mem [MAX_FREE_RANGES];
  logic [31:0] len_mem [MAX_FREE_RANGES];

  logic [31:0] pool_size;
  logic [1:0]  func_q;
  logic [31:0] size_q, align_q, foff_q;
  logic [CW-1:0] idx, pos, count;
  logic [31:0] rd_start, rd_len, prev_start, prev_len;

  logic [32:0] rnd, end33, prev_end;
  logic [31:0] flen, pad, rem;
  logic [32:0] need_base;
  logic [33:0] need;
  logic [CW-1:0] rd_idx, wr_idx;
  logic        we_start, we_len;
  logic [31:0] wd_start, wd_len;
  logic        mod_busy;

  // Request arithmetic
  assign rnd       = ({1'b0, size_q} + ffa_pkg::RND_ADD) & ffa_pkg::RND_MASK;
  assign flen      = rnd[31:0];
  assign end33     = {1'b0, foff_q} + {1'b0, flen};
  assign prev_end  = {1'b0, prev_start} + {1'b0, prev_len};
  assign need_base = (func_q == ffa_pkg::FN_ALLOC) ? rnd : {1'b0, size_q};
  assign pad       = (func_q == ffa_pkg::FN_ALIGN && rem != '0) ? align_q - rem : '0;
  assign need      = {1'b0, need_base} + {2'b0, pad};

  ffa_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (rd_start),
    .divisor  (align_q),
    .busy     (mod_busy),
    .rem      (rem)
  );

  // Status towards the controller
  always_comb begin
    sts.func       = func_q;
    sts.size_big   = size_q > ffa_pkg::SIZE_MAX;
    sts.end_big    = end33[32];
    sts.align_zero = align_q == '0;
    sts.idx_lt_cnt = idx < count;
    sts.more_rm    = (idx + CW'(1)) < count;
    sts.idx_gt_pos = idx > pos;
    sts.fit        = {2'b0, rd_len} >= need;
    sts.exact      = {2'b0, rd_len} == need;
    sts.below      = rd_start < foff_q;
    sts.mnext      = (idx < count) && (end33 == {1'b0, rd_start});
    sts.mprev      = (idx != '0) && (prev_end == {1'b0, foff_q});
    sts.full       = count == CW'(MAX_FREE_RANGES);
    sts.mod_busy   = mod_busy;
  end

  // Read address selection
  always_comb begin
    case (cmd.rd_sel)
      ffa_pkg::RD_IDX_P1: rd_idx = idx + CW'(1);
      ffa_pkg::RD_IDX_M1: rd_idx = idx - CW'(1);
      default:            rd_idx = idx;
    endcase
  end

  // Write port selection; a register write reinitialises entry zero
  always_comb begin
    wr_idx   = idx;
    we_start = 1'b0;
    we_len   = 1'b0;
    wd_start = rd_start;
    wd_len   = rd_len;
    if (cfg_we) begin
      wr_idx   = '0;
      we_start = 1'b1;
      we_len   = 1'b1;
      wd_start = '0;
      wd_len   = cfg_wdata;
    end else begin
      unique case (cmd.wr)
        ffa_pkg::WR_NONE: begin
        end
        ffa_pkg::WR_INIT: begin
          wr_idx   = '0;
          we_start = 1'b1;
          we_len   = 1'b1;
          wd_start = '0;
          wd_len   = pool_size;
        end
        ffa_pkg::WR_TRIM: begin
          we_start = 1'b1;
          we_len   = 1'b1;
          wd_start = rd_start + need[31:0];
          wd_len   = rd_len - need[31:0];
        end
        ffa_pkg::WR_SHIFT: begin
          we_start = 1'b1;
          we_len   = 1'b1;
        end
        ffa_pkg::WR_MERGE_PREV: begin
          wr_idx = idx - CW'(1);
          we_len = 1'b1;
          wd_len = prev_len + flen + (sts.mnext ? rd_len : '0);
        end
        ffa_pkg::WR_MERGE_NEXT: begin
          we_start = 1'b1;
          we_len   = 1'b1;
          wd_start = foff_q;
          wd_len   = rd_len + flen;
        end
        ffa_pkg::WR_INSERT: begin
          we_start = 1'b1;
          we_len   = 1'b1;
          wd_start = foff_q;
          wd_len   = flen;
        end
        default: begin
        end
      endcase
    end
  end

  // Range memories with registered read
  always_ff @(posedge clk) begin
    if (we_start) begin
      start_mem[wr_idx[AW-1:0]] <= wd_start;
    end
    if (we_len) begin
      len_mem[wr_idx[AW-1:0]] <= wd_len;
    end
    if (cmd.rd_en) begin
      rd_start <= start_mem[rd_idx[AW-1:0]];
      rd_len   <= len_mem[rd_idx[AW-1:0]];
    end
  end

  // Control registers: pool size, list count and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= '0;
      count     <= '0;
      idx       <= '0;
    end else begin
      if (cfg_we) begin
        pool_size <= cfg_wdata;
        count     <= CW'(1);
      end else begin
        case (cmd.cnt_op)
          ffa_pkg::CNT_ONE: count <= CW'(1);
          ffa_pkg::CNT_INC: count <= count + CW'(1);
          ffa_pkg::CNT_DEC: count <= count - CW'(1);
          default:          count <= count;
        endcase
      end
      if (cmd.load) begin
        idx <= '0;
      end else begin
        case (cmd.idx_op)
          ffa_pkg::IDX_INC:       idx <= idx + CW'(1);
          ffa_pkg::IDX_DEC:       idx <= idx - CW'(1);
          ffa_pkg::IDX_SET_COUNT: idx <= count;
          default:                idx <= idx;
        endcase
      end
    end
  end

  // Request capture, scan history and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      size_q  <= request_size;
      align_q <= alignment;
      foff_q  <= free_offset;
    end
    if (cmd.prev_ld) begin
      prev_start <= rd_start;
      prev_len   <= rd_len;
    end
    if (cmd.pos_ld) begin
      pos <= idx;
    end
    case (cmd.res)
      ffa_pkg::RES_ALLOC_OK: begin
        result_offset <= 32'({1'b0, rd_start} + {1'b0, pad});
        status        <= ffa_pkg::ST_OK;
      end
      ffa_pkg::RES_NOSPACE: begin
        result_offset <= ffa_pkg::ALL_ONES;
        status        <= ffa_pkg::ST_NOSPACE;
      end
      ffa_pkg::RES_ZALIGN: begin
        result_offset <= ffa_pkg::ALL_ONES;
        status        <= ffa_pkg::ST_ZEROALIGN;
      end
      ffa_pkg::RES_FREE_OK: begin
        result_offset <= '0;
        status        <= ffa_pkg::ST_OK;
      end
      ffa_pkg::RES_FREE_NOSPACE: begin
        result_offset <= '0;
        status        <= ffa_pkg::ST_NOSPACE;
      end
      ffa_pkg::RES_FULL: begin
        result_offset <= '0;
        status        <= ffa_pkg::ST_FULL;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/ffa_ctrl.sv =====
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_A_RD, S_A_WAIT, S_A_MOD, S_A_CHK, S_F_RD, S_F_CMP,
    S_F_DEC, S_RM_RD, S_RM_WR, S_IN_RD, S_IN_WR, S_RESP
  } state_t;

  state_t state, state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_RESP;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.wr     = ffa_pkg::WR_INIT;
        cmd.cnt_op = ffa_pkg::CNT_ONE;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_RESP;
        case (sts.func)
          ffa_pkg::FN_ALLOC: begin
            if (sts.size_big) cmd.res = ffa_pkg::RES_NOSPACE;
            else state_next = S_A_RD;
          end
          ffa_pkg::FN_ALIGN: begin
            if (sts.align_zero) cmd.res = ffa_pkg::RES_ZALIGN;
            else state_next = S_A_RD;
          end
          ffa_pkg::FN_FREE: begin
            if (sts.size_big || sts.end_big) cmd.res = ffa_pkg::RES_FREE_NOSPACE;
            else state_next = S_F_RD;
          end
          default: cmd.res = ffa_pkg::RES_NOSPACE;
        endcase
      end
      // First-fit scan, one range per pass
      S_A_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          state_next = S_A_WAIT;
        end else begin
          cmd.res    = ffa_pkg::RES_NOSPACE;
          state_next = S_RESP;
        end
      end
      S_A_WAIT: begin
        if (sts.func == ffa_pkg::FN_ALIGN) begin
          cmd.mod_start = 1'b1;
          state_next    = S_A_MOD;
        end else begin
          state_next = S_A_CHK;
        end
      end
      S_A_MOD: begin
        if (!sts.mod_busy) state_next = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.fit) begin
          cmd.res = ffa_pkg::RES_ALLOC_OK;
          if (sts.exact) begin
            state_next = S_RM_RD;
          end else begin
            cmd.wr     = ffa_pkg::WR_TRIM;
            state_next = S_RESP;
          end
        end else begin
          cmd.idx_op = ffa_pkg::IDX_INC;
          state_next = S_A_RD;
        end
      end
      // Find the insertion point of a returned range
      S_F_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          state_next = S_F_CMP;
        end else begin
          state_next = S_F_DEC;
        end
      end
      S_F_CMP: begin
        if (sts.below) begin
          cmd.prev_ld = 1'b1;
          cmd.idx_op  = ffa_pkg::IDX_INC;
          state_next  = S_F_RD;
        end else begin
          state_next = S_F_DEC;
        end
      end
      S_F_DEC: begin
        state_next = S_RESP;
        if (sts.mprev) begin
          cmd.wr  = ffa_pkg::WR_MERGE_PREV;
          cmd.res = ffa_pkg::RES_FREE_OK;
          if (sts.mnext) state_next = S_RM_RD;
        end else if (sts.mnext) begin
          cmd.wr  = ffa_pkg::WR_MERGE_NEXT;
          cmd.res = ffa_pkg::RES_FREE_OK;
        end else if (sts.full) begin
          cmd.res = ffa_pkg::RES_FULL;
        end else begin
          cmd.res    = ffa_pkg::RES_FREE_OK;
          cmd.pos_ld = 1'b1;
          cmd.idx_op = ffa_pkg::IDX_SET_COUNT;
          state_next = S_IN_RD;
        end
      end
      // Close the gap left by a removed entry
      S_RM_RD: begin
        if (sts.more_rm) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffa_pkg::RD_IDX_P1;
          state_next = S_RM_WR;
        end else begin
          cmd.cnt_op = ffa_pkg::CNT_DEC;
          state_next = S_RESP;
        end
      end
      S_RM_WR: begin
        cmd.wr     = ffa_pkg::WR_SHIFT;
        cmd.idx_op = ffa_pkg::IDX_INC;
        state_next = S_RM_RD;
      end
      // Open a gap for a new entry, working down from the end
      S_IN_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffa_pkg::RD_IDX_M1;
          state_next = S_IN_WR;
        end else begin
          cmd.wr     = ffa_pkg::WR_INSERT;
          cmd.cnt_op = ffa_pkg::CNT_INC;
          state_next = S_RESP;
        end
      end
      S_IN_WR: begin
        cmd.wr     = ffa_pkg::WR_SHIFT;
        cmd.idx_op = ffa_pkg::IDX_DEC;
        state_next = S_IN_RD;
      end
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/ffa_chk.sv =====
module ffa_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_offset,
  input logic [1:0]  status
);

  // An input transfer only happens with no result outstanding
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid)
    else $error("input transfer while a result is pending");

  // A result never appears in the cycle after an input transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result presented too early");

  // Rejected alignment reports the failure offset
  a_zalign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ffa_pkg::ST_ZEROALIGN) |-> result_offset == ffa_pkg::ALL_ONES)
    else $error("zero alignment result offset wrong");

  // A full list only arises on a free, which reports offset zero
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ffa_pkg::ST_FULL) |-> result_offset == '0)
    else $error("full list result offset wrong");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_offset) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind first_fit_free_list_allocator ffa_chk u_ffa_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_offset (result_offset),
  .status        (status)
);

// ===== test/ffa_checker.sv =====
// Watches both channels of the allocator, keeps its own copy of the free
// range list, works out the result of every request and compares it.
module ffa_checker #(
  parameter int MAX_RANGES = ffa_pkg::DEFAULT_MAX_FREE_RANGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] request_size,
  input  logic [31:0] alignment,
  input  logic [31:0] free_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_offset,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] offset;
    logic [1:0]  status;
  } alloc_result_t;

  logic [31:0]   free_start [MAX_RANGES];
  logic [31:0]   free_len   [MAX_RANGES];
  int            free_count;
  alloc_result_t awaited_results[$];

  // Drops the list entry at pos and closes the gap.
  function automatic void drop_range(int pos);
    for (int i = pos; i + 1 < free_count; i++) begin
      free_start[i] = free_start[i + 1];
      free_len[i]   = free_len[i + 1];
    end
    free_count--;
  endfunction

  // First fit: takes padding plus need from the first range that is large enough.
  function automatic alloc_result_t take_first_fit(logic [32:0] need_in, logic [31:0] align_by,
                                                   bit aligned);
    alloc_result_t res;
    logic [31:0]   pad;
    logic [31:0]   rem;
    logic [33:0]   need;
    res = '{ffa_pkg::ALL_ONES, ffa_pkg::ST_NOSPACE};
    for (int i = 0; i < free_count; i++) begin
      pad = '0;
      if (aligned) begin
        rem = free_start[i] % align_by;
        pad = (rem != 0) ? align_by - rem : '0;
      end
      need = 34'(need_in) + 34'(pad);
      if (34'(free_len[i]) >= need) begin
        res = '{free_start[i] + pad, ffa_pkg::ST_OK};
        if (34'(free_len[i]) == need) begin
          drop_range(i);
        end else begin
          free_start[i] = free_start[i] + need[31:0];
          free_len[i]   = free_len[i] - need[31:0];
        end
        return res;
      end
    end
    return res;
  endfunction

  // Returns a range to the list, merging with the following then the preceding range.
  function automatic logic [1:0] return_range(logic [31:0] start, logic [31:0] size);
    logic [32:0] len;
    logic [32:0] stop;
    int          pos;
    bit          join_next;
    bit          join_prev;
    if (size > ffa_pkg::SIZE_MAX) return ffa_pkg::ST_NOSPACE;
    len  = (33'(size) + ffa_pkg::RND_ADD) & ffa_pkg::RND_MASK;
    stop = 33'(start) + len;
    if (stop > 33'(ffa_pkg::ALL_ONES)) return ffa_pkg::ST_NOSPACE;
    pos = 0;
    while (pos < free_count && free_start[pos] < start) pos++;
    join_next = pos < free_count && stop == 33'(free_start[pos]);
    join_prev = pos > 0 && 33'(free_start[pos - 1]) + 33'(free_len[pos - 1]) == 33'(start);
    if (join_next && join_prev) begin
      free_len[pos - 1] = free_len[pos - 1] + len[31:0] + free_len[pos];
      drop_range(pos);
    end else if (join_prev) begin
      free_len[pos - 1] = free_len[pos - 1] + len[31:0];
    end else if (join_next) begin
      free_start[pos] = start;
      free_len[pos]   = free_len[pos] + len[31:0];
    end else begin
      if (free_count >= MAX_RANGES) return ffa_pkg::ST_FULL;
      for (int i = free_count; i > pos; i--) begin
        free_start[i] = free_start[i - 1];
        free_len[i]   = free_len[i - 1];
      end
      free_start[pos] = start;
      free_len[pos]   = len[31:0];
      free_count++;
    end
    return ffa_pkg::ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] fn, logic [31:0] size,
                                                    logic [31:0] align_by, logic [31:0] start);
    alloc_result_t res;
    res = '{ffa_pkg::ALL_ONES, ffa_pkg::ST_NOSPACE};
    case (fn)
      ffa_pkg::FN_ALLOC: begin
        if (size <= ffa_pkg::SIZE_MAX)
          res = take_first_fit((33'(size) + ffa_pkg::RND_ADD) & ffa_pkg::RND_MASK, 32'd1, 1'b0);
      end
      ffa_pkg::FN_ALIGN: begin
        if (align_by == '0) res.status = ffa_pkg::ST_ZEROALIGN;
        else res = take_first_fit(33'(size), align_by, 1'b1);
      end
      ffa_pkg::FN_FREE: begin
        res = '{32'd0, return_range(start, size)};
      end
      default: ;
    endcase
    return res;
  endfunction

  // Tracks configuration writes, accepted requests and accepted results.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      free_start[0] = '0;
      free_len[0] = '0;
      free_count = 1;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        free_start[0] = '0;
        free_len[0] = cfg_wdata;
        free_count = 1;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: offset %h status %0d",
                   $time, result_offset, status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result_offset !== want.offset) begin
            $display("%0t: offset mismatch: expected %h actual %h",
                     $time, want.offset, result_offset);
            fail_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results = {awaited_results,
                           predict_request(func, request_size, alignment, free_offset)};
    end
    pending = awaited_results.size();
  end

endmodule

// ===== test/tb_first_fit_free_list_allocator.sv =====
module tb_first_fit_free_list_allocator;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_REQUESTS = 1200;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [31:0] request_size;
  logic [31:0] alignment;
  logic [31:0] free_offset;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_offset;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          quiet_phase;
  bit          long_hold;

  // Recently granted blocks, so that frees mostly return real allocations.
  logic [31:0] held_offset[$];

  first_fit_free_list_allocator u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .func, .request_size,
    .alignment, .free_offset, .out_valid, .out_ready, .result_offset, .status
  );

  ffa_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .func, .request_size,
    .alignment, .free_offset, .out_valid, .out_ready, .result_offset, .status,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Records granted blocks from result transfers.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && status == ffa_pkg::ST_OK && result_offset != '0
        && held_offset.size() < 200) begin
      held_offset = {held_offset, result_offset};
    end
  end

  // Valid stays high after a transfer until the next request or an idle gap.
  task automatic send_request(logic [1:0] fn, logic [31:0] size, logic [31:0] align_by,
                              logic [31:0] start);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= fn;
    request_size <= size;
    alignment    <= align_by;
    free_offset  <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_pool(logic [31:0] bytes);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    held_offset.delete();
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 4095);
      2: return $urandom_range(0, 65535);
      3: return $urandom();
      default: return 32'(($urandom_range(1, 16)) * 256);
    endcase
  endfunction

  function automatic logic [31:0] pick_align();
    case ($urandom_range(0, 4))
      0: return 32'd1 << $urandom_range(0, 31);
      1: return $urandom_range(1, 5000);
      2: return $urandom();
      default: return 32'd1 << $urandom_range(4, 12);
    endcase
  endfunction

  task automatic random_request();
    int          pick;
    logic [31:0] start;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_request(ffa_pkg::FN_ALLOC, pick_size(), $urandom(), $urandom());
    end else if (pick < 55) begin
      send_request(ffa_pkg::FN_ALIGN, pick_size(),
                   ($urandom_range(0, 30) == 0) ? '0 : pick_align(), $urandom());
    end else if (pick < 90 && held_offset.size() > 0) begin
      // Return a slice of a granted block, which makes merges and fragments.
      start = held_offset.pop_front();
      send_request(ffa_pkg::FN_FREE, 32'($urandom_range(1, 8) * 256) - $urandom_range(0, 255),
                   $urandom(), start);
    end else if (pick < 97) begin
      send_request(ffa_pkg::FN_FREE, pick_size(), $urandom(), $urandom());
    end else begin
      send_request(FN_UNUSED, $urandom(), $urandom(), $urandom());
    end
  endtask

  // Stimulus.
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    func         = ffa_pkg::FN_ALLOC;
    request_size = '0;
    alignment    = '0;
    free_offset  = '0;
    quiet_phase  = 1'b0;
    long_hold    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pool after reset, then size extremes and special cases.
    send_request(ffa_pkg::FN_ALLOC, 32'd0, '0, '0);
    send_request(ffa_pkg::FN_ALLOC, 32'd1, '0, '0);
    write_pool(ffa_pkg::ALL_ONES);
    send_request(ffa_pkg::FN_ALLOC, 32'hFFFF_FF01, '0, '0);
    send_request(ffa_pkg::FN_ALLOC, ffa_pkg::SIZE_MAX, '0, '0);
    send_request(ffa_pkg::FN_ALLOC, 32'd0, '0, '0);
    send_request(ffa_pkg::FN_ALLOC, 32'd255, '0, '0);
    send_request(ffa_pkg::FN_FREE, 32'd0, '0, '0);
    send_request(ffa_pkg::FN_FREE, 32'd1, '0, 32'h0000_0100);
    send_request(ffa_pkg::FN_FREE, 32'hFFFF_FF01, '0, '0);
    send_request(ffa_pkg::FN_FREE, 32'd256, '0, 32'hFFFF_FF80);
    send_request(ffa_pkg::FN_ALIGN, 32'd10, '0, '0);
    send_request(ffa_pkg::FN_ALIGN, 32'd7, 32'h8000_0000, '0);
    send_request(ffa_pkg::FN_ALIGN, 32'd0, ffa_pkg::ALL_ONES, '0);
    send_request(FN_UNUSED, ffa_pkg::ALL_ONES, ffa_pkg::ALL_ONES, ffa_pkg::ALL_ONES);
    write_pool(32'd1024);
    send_request(ffa_pkg::FN_ALLOC, 32'd1024, '0, '0);
    send_request(ffa_pkg::FN_ALLOC, 32'd0, '0, '0);
    send_request(ffa_pkg::FN_FREE, 32'd256, '0, 32'd256);
    send_request(ffa_pkg::FN_FREE, 32'd256, '0, 32'd768);
    send_request(ffa_pkg::FN_FREE, 32'd256, '0, 32'd512);
    send_request(ffa_pkg::FN_FREE, 32'd256, '0, 32'd0);

    // Fill the list with scattered frees until it reports full.
    write_pool(32'd0);
    for (int i = 0; i < 66; i++) send_request(ffa_pkg::FN_FREE, 32'd16, '0, 32'(i * 1024));

    // Random phases over several pool sizes; the sender pauses to drain between.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_pool(32'h0010_0000);
        1: write_pool($urandom_range(0, 65535));
        2: write_pool($urandom());
        default: write_pool(32'h0004_0000);
      endcase
      if (ph == 1) long_hold = 1'b1;
      if (ph == 3) quiet_phase = 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS / 4; n++) random_request();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
